/* sv/gha_pkg.sv */
// Package for the generational handle allocator: field widths, operation
// and status codes, default sizes and the table write-enable bundle.
// No dependencies.
`timescale 1ns / 1ps

package gha_pkg;

	localparam int unsigned KIND_W   = 2;
	localparam int unsigned SLOT_W   = 10;
	localparam int unsigned VER_W    = 16;
	localparam int unsigned STATUS_W = 2;

	localparam int unsigned MAX_SLOTS_DEF    = 1024;
	localparam int unsigned VERSION_BITS_DEF = 16;

	localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

	typedef struct packed {
		logic link_we;
		logic ver_we;
	} gha_wr_en_t;

endpackage

/* sv/gha_if.sv */
// Valid/ready channel interfaces: request beats (kind, slot, version) and
// response beats (out_slot, out_version, status). Depends on gha_pkg.
`timescale 1ns / 1ps

interface gha_req_if;
	import gha_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [SLOT_W-1:0] slot;
	logic [VER_W-1:0]  version;

	modport source (output valid, output kind, output slot, output version, input ready);
	modport sink   (input valid, input kind, input slot, input version, output ready);
endinterface

interface gha_rsp_if;
	import gha_pkg::*;

	logic                valid;
	logic                ready;
	logic [SLOT_W-1:0]   out_slot;
	logic [VER_W-1:0]    out_version;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output out_slot, output out_version, output status,
		input ready);
	modport sink   (input valid, input out_slot, input out_version, input status,
		output ready);
endinterface

/* sv/gha_table.sv */
// Slot table: next-link and version memories, one shared read address with
// registered read data, one shared write address. Depends on gha_pkg.
`timescale 1ns / 1ps

module gha_table #(
	parameter int unsigned MAX_SLOTS    = gha_pkg::MAX_SLOTS_DEF,
	parameter int unsigned VERSION_BITS = gha_pkg::VERSION_BITS_DEF,
	localparam int unsigned SW = $clog2(MAX_SLOTS),
	localparam int unsigned LW = $clog2(MAX_SLOTS + 1)
) (
	input  logic                    clk,
	input  logic                    rd_en,
	input  logic [SW-1:0]           rd_addr,
	output logic [LW-1:0]           rd_link,
	output logic [VERSION_BITS-1:0] rd_ver,
	input  gha_pkg::gha_wr_en_t     wr_en,
	input  logic [SW-1:0]           wr_addr,
	input  logic [LW-1:0]           wr_link,
	input  logic [VERSION_BITS-1:0] wr_ver
);
	import gha_pkg::*;

	logic [LW-1:0]           link_mem [MAX_SLOTS];
	logic [VERSION_BITS-1:0] ver_mem  [MAX_SLOTS];
	logic [LW-1:0]           rd_link_q;
	logic [VERSION_BITS-1:0] rd_ver_q;

	always_ff @(posedge clk) begin
		if (wr_en.link_we) begin
			link_mem[wr_addr] <= wr_link;
		end
		if (wr_en.ver_we) begin
			ver_mem[wr_addr] <= wr_ver;
		end
	end

	// read data holds between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_link_q <= link_mem[rd_addr];
			rd_ver_q  <= ver_mem[rd_addr];
		end
	end

	assign rd_link = rd_link_q;
	assign rd_ver  = rd_ver_q;

endmodule

/* sv/generational_handle_allocator_core.sv */
// Generational handle allocator core. Depends on gha_pkg, gha_if, gha_table.
// A response beat is registered in the output register after the table read and the execute step;
// operations do not overlap: each is one table read, then modify/write,
// in the single read-modify-write pass through the slot table.
// Reset: free-list head goes to empty and the issued count to zero at once;
// the table memories are not cleared, so no clearing pass is needed.
`timescale 1ns / 1ps

module generational_handle_allocator_core #(
	parameter int unsigned MAX_SLOTS    = gha_pkg::MAX_SLOTS_DEF,
	parameter int unsigned VERSION_BITS = gha_pkg::VERSION_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	gha_req_if.sink  req,
	gha_rsp_if.source rsp
);
	import gha_pkg::*;

	localparam int unsigned SW  = $clog2(MAX_SLOTS);
	localparam int unsigned LW  = $clog2(MAX_SLOTS + 1);
	// common widths for slot and version comparisons against port fields
	localparam int unsigned CW  = (LW > SLOT_W) ? LW : SLOT_W;
	localparam int unsigned VCW = (VERSION_BITS > VER_W) ? VERSION_BITS : VER_W;

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_EXEC = 1'b1;

	logic [0:0] state_q;
	logic [LW-1:0] free_head_q;
	logic [LW-1:0] issued_q;

	// request captured at accept; table read launched on the same edge
	logic [KIND_W-1:0]       kind_s1;
	logic [CW-1:0]           slot_s1;
	logic [VERSION_BITS-1:0] ver_s1;

	logic                rsp_valid_q;
	logic [SLOT_W-1:0]   rsp_slot_q;
	logic [VER_W-1:0]    rsp_ver_q;
	logic [STATUS_W-1:0] rsp_status_q;

	logic                    req_fire;
	logic                    exec_fire;
	logic [CW-1:0]           req_slot_cw;
	logic [SW-1:0]           rd_addr;
	logic [LW-1:0]           rd_link;
	logic [VERSION_BITS-1:0] rd_ver;

	gha_wr_en_t              wr_en;
	logic [SW-1:0]           wr_addr;
	logic [VERSION_BITS-1:0] wr_ver;

	logic                    list_empty;
	logic                    table_full;
	logic                    handle_ok;
	logic [LW-1:0]           free_head_d;
	logic [LW-1:0]           issued_d;
	logic [CW-1:0]           res_slot;
	logic [VERSION_BITS-1:0] res_ver;
	logic [STATUS_W-1:0]     res_status;

	// One operation in flight. The write-back lands on the same edge that
	// frees the request side, so the next read always sees updated entries:
	// the state machine is the interlock and no forwarding is needed.
	assign req.ready  = (state_q == S_IDLE);
	assign req_fire   = req.valid && req.ready;
	// a finished result may wait in the output register; only a second
	// result stalls the execute step
	assign exec_fire  = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);

	assign req_slot_cw = CW'(req.slot);
	// create reads the free-list head entry, destroy/check the handle's slot
	assign rd_addr = (req.kind == KIND_CREATE) ? free_head_q[SW-1:0] : req_slot_cw[SW-1:0];

	gha_table #(
		.MAX_SLOTS    (MAX_SLOTS),
		.VERSION_BITS (VERSION_BITS)
	) u_table (
		.clk     (clk),
		.rd_en   (req_fire),
		.rd_addr (rd_addr),
		.rd_link (rd_link),
		.rd_ver  (rd_ver),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_link (free_head_q),
		.wr_ver  (wr_ver)
	);

	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_s1 <= req.kind;
			slot_s1 <= req_slot_cw;
			// only the low VERSION_BITS of the handle version take part
			ver_s1  <= VERSION_BITS'(VCW'(req.version));
		end
	end

	assign list_empty = (free_head_q == LW'(MAX_SLOTS));
	assign table_full = (issued_q >= LW'(MAX_SLOTS - 1));
	assign handle_ok  = (slot_s1 < CW'(issued_q)) && (rd_ver == ver_s1);

	always_comb begin
		wr_en       = '0;
		wr_addr     = slot_s1[SW-1:0];
		wr_ver      = rd_ver + VERSION_BITS'(1);
		free_head_d = free_head_q;
		issued_d    = issued_q;
		res_slot    = '0;
		res_ver     = '0;
		res_status  = ST_OK;
		unique case (kind_s1)
			KIND_CREATE: begin
				if (!list_empty) begin
					// reuse the head slot under its bumped version
					res_slot    = CW'(free_head_q);
					res_ver     = rd_ver;
					free_head_d = rd_link;
				end else if (table_full) begin
					res_status = ST_FULL;
				end else begin
					// append a fresh slot at version zero
					wr_en.ver_we = 1'b1;
					wr_addr      = issued_q[SW-1:0];
					wr_ver       = '0;
					res_slot     = CW'(issued_q);
					issued_d     = issued_q + LW'(1);
				end
			end
			KIND_DESTROY: begin
				if (handle_ok) begin
					wr_en.link_we = 1'b1;
					wr_en.ver_we  = 1'b1;
					free_head_d   = slot_s1[LW-1:0];
				end else begin
					res_status = ST_STALE;
				end
			end
			KIND_CHECK: begin
				if (!handle_ok) begin
					res_status = ST_STALE;
				end
			end
			default: begin
				res_status = ST_STALE;
			end
		endcase
		if (!exec_fire) begin
			wr_en = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= LW'(MAX_SLOTS);
			issued_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_fire) begin
						state_q     <= S_IDLE;
						free_head_q <= free_head_d;
						issued_q    <= issued_d;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			rsp_slot_q   <= SLOT_W'(res_slot);
			rsp_ver_q    <= VER_W'(VCW'(res_ver));
			rsp_status_q <= res_status;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.out_slot    = rsp_slot_q;
	assign rsp.out_version = rsp_ver_q;
	assign rsp.status      = rsp_status_q;

endmodule
